/* hdl/acm_pkg.sv */
// acm_pkg: shared types, constants and helpers of the audio channel mixer
// no dependencies; imported by the interfaces and every mixer module
`default_nettype none

package acm_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_CHANNELS   = 4;
   localparam int CNT_BITS       = 3;
   localparam int VOL_BITS       = 9;
   localparam int VOL_SHIFT      = 8;
   localparam int PROD_BITS      = SAMPLE_BITS + VOL_BITS + 1;
   localparam int SUM_BITS       = SAMPLE_BITS + 2;
   localparam int RECIP_BITS     = 16;
   localparam int RECIP_SHIFT    = 17;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = VOL_BITS;

   localparam logic [VOL_BITS-1:0]   UNITY_VOL   = VOL_BITS'(256);
   localparam logic [CNT_BITS-1:0]   CNT_ONE     = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0]   CNT_TWO     = CNT_BITS'(2);
   localparam logic [CNT_BITS-1:0]   CNT_THREE   = CNT_BITS'(3);
   localparam logic [CNT_BITS-1:0]   CNT_MAX     = CNT_BITS'(MAX_CHANNELS);
   localparam logic [RECIP_BITS-1:0] RECIP_THREE = RECIP_BITS'(43691);

   localparam logic [CSR_INDEX_BITS-1:0] REG_SRC_CHANNELS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DST_CHANNELS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIX_ALL      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VOL_CH0      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VOL_CH1      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VOL_CH2      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VOL_CH3      = 3'd6;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] ns;
      logic [CNT_BITS-1:0] nd;
      logic                all;
   } mix_mode_type;

   function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] c);
      logic [CNT_BITS-1:0] r;
      r = c;
      if (c == '0) begin
         r = CNT_ONE;
      end else if (c > CNT_MAX) begin
         r = CNT_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/acm_if.sv */
// acm_if: request, response and register write channels of the mixer
// depends on acm_pkg for the sample type and register port widths
`default_nettype none

interface acm_req_if import acm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type in_s0;
   sample_type in_s1;
   sample_type in_s2;
   sample_type in_s3;

   modport source (output valid, output in_s0, output in_s1, output in_s2, output in_s3,
                   input ready);
   modport sink   (input valid, input in_s0, input in_s1, input in_s2, input in_s3,
                   output ready);
endinterface

interface acm_rsp_if import acm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type out_s0;
   sample_type out_s1;
   sample_type out_s2;
   sample_type out_s3;

   modport source (output valid, output out_s0, output out_s1, output out_s2,
                   output out_s3, input ready);
   modport sink   (input valid, input out_s0, input out_s1, input out_s2, input out_s3,
                   output ready);
endinterface

interface acm_csr_if import acm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/acm_lane.sv */
// acm_lane: one channel lane, volume saturation and multiply, truncating scale by 256
// depends on acm_pkg
`default_nettype none

module acm_lane import acm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire logic                active,
   input  wire logic [VOL_BITS-1:0] vol,
   input  wire sample_type          sample,
   output      sample_type          scaled
);

   localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'((1 << VOL_SHIFT) - 1);

   logic [VOL_BITS-1:0]          vol_eff;
   logic signed [PROD_BITS-1:0]  product_in;
   logic signed [PROD_BITS-1:0]  product_ff;
   logic signed [PROD_BITS-1:0]  biased;

   always_comb begin
      vol_eff = (vol > UNITY_VOL) ? UNITY_VOL : vol;
      if (!active) begin
         vol_eff = '0;
      end
      product_in = sample * $signed({1'b0, vol_eff});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   // toward-zero rounding for negative products
   assign biased = product_ff + (product_ff[PROD_BITS-1] ? ROUND_BIAS : '0);
   assign scaled = biased[SAMPLE_BITS+VOL_SHIFT-1:VOL_SHIFT];

endmodule

`default_nettype wire

/* hdl/acm_merge.sv */
// acm_merge: sums the lane results, divides the downmix sum and maps source to destination
// depends on acm_pkg; fed by the acm_lane instances
`default_nettype none

module acm_merge import acm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         load,
   input  wire mix_mode_type mode,
   input  wire sample_type   lane_s [MAX_CHANNELS],
   output      sample_type   dst_s  [MAX_CHANNELS]
);

   localparam int MUL_BITS = (SUM_BITS - 1) + RECIP_BITS;

   logic signed [SUM_BITS-1:0] sum;
   logic [SUM_BITS-1:0]        mag_in;
   logic [SUM_BITS-1:0]        mag_ff;
   logic                       neg_ff;
   logic [CNT_BITS-1:0]        div_in;
   logic [CNT_BITS-1:0]        div_ff;
   sample_type                 frame_ff [MAX_CHANNELS];
   logic [MUL_BITS-1:0]        recip_prod;
   logic [SUM_BITS-1:0]        quot;
   logic [SUM_BITS-1:0]        avg_wide;
   sample_type                 avg;

   always_comb begin
      sum = SUM_BITS'(lane_s[0]) + SUM_BITS'(lane_s[1]);
      if (mode.all) begin
         for (int ch = 2; ch < MAX_CHANNELS; ch++) begin
            sum = sum + SUM_BITS'(lane_s[ch]);
         end
      end
      mag_in = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
      div_in = mode.all ? mode.ns : CNT_TWO;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= lane_s;
         mag_ff   <= mag_in;
         neg_ff   <= sum[SUM_BITS-1];
         div_ff   <= div_in;
      end
   end

   // divide by three as a reciprocal multiply, exact below 2**17
   assign recip_prod = mag_ff[SUM_BITS-2:0] * RECIP_THREE;

   always_comb begin
      case (div_ff)
         CNT_TWO:   quot = mag_ff >> 1;
         CNT_THREE: quot = SUM_BITS'(recip_prod[MUL_BITS-1:RECIP_SHIFT]);
         CNT_MAX:   quot = mag_ff >> 2;
         default:   quot = mag_ff;
      endcase
      avg_wide = neg_ff ? SUM_BITS'(-quot) : quot;
      avg      = $signed(avg_wide[SAMPLE_BITS-1:0]);
   end

   always_comb begin
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
         dst_s[ch] = '0;
         if (mode.ns == mode.nd) begin
            if (CNT_BITS'(ch) < mode.nd) begin
               dst_s[ch] = frame_ff[ch];
            end
         end else if (mode.ns >= CNT_TWO && mode.nd == CNT_ONE) begin
            if (ch == 0) begin
               dst_s[ch] = avg;
            end
         end else if (mode.ns == CNT_ONE && mode.nd >= CNT_TWO) begin
            if (mode.all ? (CNT_BITS'(ch) < mode.nd) : (CNT_BITS'(ch) < CNT_TWO)) begin
               dst_s[ch] = frame_ff[0];
            end
         end else begin
            if (CNT_BITS'(ch) < mode.nd) begin
               dst_s[ch] = frame_ff[ch];
            end
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/audio_channel_mixer_unit.sv */
// audio_channel_mixer_unit: top level, register file, lanes, merge and output register
// depends on acm_pkg, acm_if, acm_lane and acm_merge
// pipeline: three register stages (lane, merge, output) from request transfer to response valid
// throughput: one frame per cycle while rsp_chan.ready is high; each stage holds only while the stage after it is full
// reset: pipeline empty, src_channels and dst_channels 1, mix_all 0, all volumes 256
// register writes always complete in the cycle they are offered
`default_nettype none

module audio_channel_mixer_unit import acm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   acm_req_if.sink   req_chan,
   acm_rsp_if.source rsp_chan,
   acm_csr_if.sink   csr_chan
);

   logic [CNT_BITS-1:0] src_ff, src_in;
   logic [CNT_BITS-1:0] dst_ff, dst_in;
   logic                mix_ff, mix_in;
   logic [VOL_BITS-1:0] vol_ff [MAX_CHANNELS];
   logic [VOL_BITS-1:0] vol_in [MAX_CHANNELS];

   logic         lane_valid_ff, lane_valid_in;
   logic         merge_valid_ff, merge_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_xfer, merge_load, out_load;
   mix_mode_type mode;
   sample_type   req_s   [MAX_CHANNELS];
   sample_type   lane_s  [MAX_CHANNELS];
   sample_type   dst_s   [MAX_CHANNELS];
   sample_type   rsp_s_ff [MAX_CHANNELS];

   // register file
   assign csr_chan.ready = 1'b1;

   always_comb begin
      src_in = src_ff;
      dst_in = dst_ff;
      mix_in = mix_ff;
      vol_in = vol_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_SRC_CHANNELS: src_in    = csr_chan.data[CNT_BITS-1:0];
            REG_DST_CHANNELS: dst_in    = csr_chan.data[CNT_BITS-1:0];
            REG_MIX_ALL:      mix_in    = csr_chan.data[0];
            REG_VOL_CH0:      vol_in[0] = csr_chan.data;
            REG_VOL_CH1:      vol_in[1] = csr_chan.data;
            REG_VOL_CH2:      vol_in[2] = csr_chan.data;
            REG_VOL_CH3:      vol_in[3] = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= CNT_ONE;
         dst_ff <= CNT_ONE;
         mix_ff <= 1'b0;
         for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            vol_ff[ch] <= UNITY_VOL;
         end
      end else begin
         src_ff <= src_in;
         dst_ff <= dst_in;
         mix_ff <= mix_in;
         vol_ff <= vol_in;
      end
   end

   assign mode.ns  = clamp_count(src_ff);
   assign mode.nd  = clamp_count(dst_ff);
   assign mode.all = mix_ff;

   // pipeline flow control
   assign out_load       = merge_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign merge_load     = lane_valid_ff && (!merge_valid_ff || out_load);
   assign req_chan.ready = !lane_valid_ff || merge_load;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign lane_valid_in  = req_xfer || (lane_valid_ff && !merge_load);
   assign merge_valid_in = merge_load || (merge_valid_ff && !out_load);
   assign rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff  <= 1'b0;
         merge_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         lane_valid_ff  <= lane_valid_in;
         merge_valid_ff <= merge_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // lanes
   assign req_s[0] = req_chan.in_s0;
   assign req_s[1] = req_chan.in_s1;
   assign req_s[2] = req_chan.in_s2;
   assign req_s[3] = req_chan.in_s3;

   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      acm_lane u_lane (
         .clock  (clock),
         .load   (req_xfer),
         .active (CNT_BITS'(g) < mode.ns),
         .vol    (vol_ff[g]),
         .sample (req_s[g]),
         .scaled (lane_s[g])
      );
   end

   acm_merge u_merge (
      .clock  (clock),
      .load   (merge_load),
      .mode   (mode),
      .lane_s (lane_s),
      .dst_s  (dst_s)
   );

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_s_ff <= dst_s;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.out_s0 = rsp_s_ff[0];
   assign rsp_chan.out_s1 = rsp_s_ff[1];
   assign rsp_chan.out_s2 = rsp_s_ff[2];
   assign rsp_chan.out_s3 = rsp_s_ff[3];

endmodule

`default_nettype wire
